// ----- design/atd_pkg.sv -----
// Shared constants, command type and arctangent table for the tilt angle block.
package atd_pkg;

	localparam int SAMPLE_BITS  = 16;
	localparam int ANGLE_BITS   = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int SQRT_STEPS   = 32;
	localparam int SCALE_STEPS  = 4;
	localparam int THR_BITS     = 15;
	localparam logic [THR_BITS-1:0] THRESHOLD_MAX   = 15'd16384;
	localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 15'd182;

	localparam logic [0:0] REG_THRESHOLD = 1'b0;
	localparam logic [0:0] REG_UNIT      = 1'b1;

	// datapath operations
	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_LOAD     = 4'd1;
	localparam logic [3:0] OP_CAL      = 4'd2;
	localparam logic [3:0] OP_SQA      = 4'd3;
	localparam logic [3:0] OP_SQB      = 4'd4;
	localparam logic [3:0] OP_SQRT_INI = 4'd5;
	localparam logic [3:0] OP_SQRT_STP = 4'd6;
	localparam logic [3:0] OP_CORD_INI = 4'd7;
	localparam logic [3:0] OP_CORD_STP = 4'd8;
	localparam logic [3:0] OP_ANGLE    = 4'd9;
	localparam logic [3:0] OP_POST     = 4'd10;
	localparam logic [3:0] OP_SCALE    = 4'd11;
	localparam logic [3:0] OP_PUBLISH  = 4'd12;

	typedef struct packed {
		logic [3:0] op;
		logic       axis;   // 0 pitch, 1 roll
		logic [4:0] step;
	} cmd_t;

	// atan(2^-i), binary angle with pi = 2^31
	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

endpackage

// ----- design/atd_ctrl.sv -----
// Sequencer for the tilt angle block: steps the shared square root and CORDIC units.
module atd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_mode,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output atd_pkg::cmd_t cmd
);
	import atd_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SQA   = 4'd1;
	localparam logic [3:0] ST_SQB   = 4'd2;
	localparam logic [3:0] ST_SINI  = 4'd3;
	localparam logic [3:0] ST_SQRT  = 4'd4;
	localparam logic [3:0] ST_CINI  = 4'd5;
	localparam logic [3:0] ST_CORD  = 4'd6;
	localparam logic [3:0] ST_ANGLE = 4'd7;
	localparam logic [3:0] ST_POST  = 4'd8;
	localparam logic [3:0] ST_SCALE = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	logic [3:0] state_q, state_d;
	logic       axis_q, axis_d;
	logic [4:0] step_q, step_d;
	logic       out_valid_q, out_valid_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		axis_d      = axis_q;
		step_d      = step_q;
		out_valid_d = out_valid_q & ~out_ready;
		cmd.op      = OP_NONE;
		cmd.axis    = axis_q;
		cmd.step    = step_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_mode) begin
						cmd.op = OP_CAL;
					end else begin
						cmd.op  = OP_LOAD;
						axis_d  = 1'b0;
						state_d = ST_SQA;
					end
				end
			end
			ST_SQA: begin
				cmd.op  = OP_SQA;
				state_d = ST_SQB;
			end
			ST_SQB: begin
				cmd.op  = OP_SQB;
				state_d = ST_SINI;
			end
			ST_SINI: begin
				cmd.op  = OP_SQRT_INI;
				step_d  = '0;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.op = OP_SQRT_STP;
				step_d = step_q + 5'd1;
				if (step_q == 5'(SQRT_STEPS - 1)) begin
					state_d = ST_CINI;
				end
			end
			ST_CINI: begin
				cmd.op  = OP_CORD_INI;
				step_d  = '0;
				state_d = ST_CORD;
			end
			ST_CORD: begin
				cmd.op = OP_CORD_STP;
				step_d = step_q + 5'd1;
				if (step_q == 5'(CORDIC_STEPS - 1)) begin
					state_d = ST_ANGLE;
				end
			end
			ST_ANGLE: begin
				cmd.op = OP_ANGLE;
				if (!axis_q) begin
					axis_d  = 1'b1;
					state_d = ST_SQA;
				end else begin
					state_d = ST_POST;
				end
			end
			ST_POST: begin
				cmd.op  = OP_POST;
				step_d  = '0;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.op = OP_SCALE;
				step_d = step_q + 5'd1;
				if (step_q == 5'(SCALE_STEPS - 1)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.op      = OP_PUBLISH;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			axis_q      <= axis_d;
			step_q      <= step_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

// ----- design/atd_dp.sv -----
// Datapath: squares, bitwise square root, CORDIC arctangent, deadband and unit scaling.
module atd_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  atd_pkg::cmd_t                   cmd,
	input  logic signed [15:0]              accel_x,
	input  logic signed [15:0]              accel_y,
	input  logic signed [15:0]              accel_z,
	input  logic [atd_pkg::THR_BITS-1:0]    threshold,
	input  logic                            unit_deg,
	output logic signed [14:0]              x_rotation,
	output logic signed [14:0]              y_rotation,
	output logic [14:0]                     delta_x,
	output logic [14:0]                     delta_y,
	output logic                            x_changed,
	output logic                            y_changed
);
	import atd_pkg::*;

	logic signed [15:0] ax_q, ay_q, az_q;
	logic [31:0]        sq_a_q, sq_b_q;
	logic [63:0]        rem_q;
	logic [63:0]        root_q;
	logic signed [35:0] cx_q, cy_q;
	logic signed [33:0] cz_q;
	logic               zero_q;
	logic signed [15:0] last_pitch_q, last_roll_q, pitch_off_q, roll_off_q;
	logic signed [15:0] held_x_q, held_y_q;
	logic [15:0]        dx_q, dy_q;
	logic               xc_q, yc_q;
	logic signed [14:0] res_xr_q, res_yr_q;
	logic [14:0]        res_dx_q, res_dy_q;

	// operand selection per axis: pitch uses x over (y,z), roll uses y over (x,z)
	logic signed [15:0] num, opa, sq_src;
	logic [31:0]        sq;
	assign num    = cmd.axis ? ay_q : ax_q;
	assign opa    = cmd.axis ? ax_q : ay_q;
	assign sq_src = (cmd.op == OP_SQA) ? opa : az_q;
	assign sq     = 32'(sq_src) * 32'(sq_src);

	// square root step; the partial root runs as wide as the remainder
	logic [63:0] sbit, trial;
	logic        take;
	assign sbit  = 64'd1 << (7'd62 - {1'b0, cmd.step, 1'b0});
	assign trial = root_q + sbit;
	assign take  = rem_q >= trial;

	// CORDIC step
	logic signed [35:0] shx, shy;
	logic signed [33:0] at;
	assign shx = cy_q >>> cmd.step;
	assign shy = cx_q >>> cmd.step;
	assign at  = $signed({2'b00, atan_entry(cmd.step)});

	logic signed [33:0] zr;
	logic signed [15:0] ang;
	assign zr  = cz_q + 34'sd32768;
	assign ang = zero_q ? 16'sd0 : (cmd.axis ? zr[31:16] : -zr[31:16]);

	// wrap and fold into +-pi/2
	function automatic logic signed [15:0] fold16(input logic signed [15:0] v);
		logic signed [16:0] w;
		w = {v[15], v};
		if (w > 17'sd16384) begin
			w = 17'sd32768 - w;
		end else if (w < -17'sd16384) begin
			w = -17'sd32768 - w;
		end
		return w[15:0];
	endfunction

	logic signed [15:0] xrot, yrot;
	logic signed [16:0] ddx, ddy;
	logic [15:0]        adx, ady;
	logic               xc, yc;
	assign xrot = fold16(last_roll_q - roll_off_q);
	assign yrot = fold16(last_pitch_q - pitch_off_q);
	assign ddx  = {xrot[15], xrot} - {held_x_q[15], held_x_q};
	assign ddy  = {yrot[15], yrot} - {held_y_q[15], held_y_q};
	assign adx  = ddx[16] ? 16'(-ddx) : ddx[15:0];
	assign ady  = ddy[16] ? 16'(-ddy) : ddy[15:0];
	assign xc   = adx >= {1'b0, threshold};
	assign yc   = ady >= {1'b0, threshold};

	// unit scaling, one value per step
	logic               sc_neg;
	logic [15:0]        sc_mag;
	logic [31:0]        sc_prod;
	logic [32:0]        sc_rnd;
	logic [14:0]        sc_r, sc_out;
	always_comb begin
		sc_neg = 1'b0;
		sc_mag = '0;
		case (cmd.step[1:0])
			2'd0: begin
				sc_neg = held_x_q[15];
				sc_mag = held_x_q[15] ? 16'(-held_x_q) : held_x_q;
			end
			2'd1: begin
				sc_neg = held_y_q[15];
				sc_mag = held_y_q[15] ? 16'(-held_y_q) : held_y_q;
			end
			2'd2: sc_mag = dx_q;
			2'd3: sc_mag = dy_q;
			default: sc_mag = '0;
		endcase
		sc_prod = sc_mag * (unit_deg ? 16'd45 : 16'd51472);
		sc_rnd  = {1'b0, sc_prod} + (unit_deg ? 33'd32 : 33'd32768);
		sc_r    = unit_deg ? sc_rnd[20:6] : sc_rnd[30:16];
		sc_out  = sc_neg ? 15'(-sc_r) : sc_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pitch_q <= '0;
			last_roll_q  <= '0;
			pitch_off_q  <= '0;
			roll_off_q   <= '0;
			held_x_q     <= '0;
			held_y_q     <= '0;
		end else begin
			case (cmd.op)
				OP_CAL: begin
					pitch_off_q <= last_pitch_q;
					roll_off_q  <= last_roll_q;
				end
				OP_ANGLE: begin
					if (cmd.axis) last_roll_q <= ang;
					else last_pitch_q <= ang;
				end
				OP_POST: begin
					if (xc) held_x_q <= xrot;
					if (yc) held_y_q <= yrot;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				ax_q <= accel_x;
				ay_q <= accel_y;
				az_q <= accel_z;
			end
			OP_SQA: sq_a_q <= sq;
			OP_SQB: sq_b_q <= sq;
			OP_SQRT_INI: begin
				rem_q  <= {sq_a_q + sq_b_q, 32'd0};
				root_q <= '0;
			end
			OP_SQRT_STP: begin
				if (take) begin
					rem_q  <= rem_q - trial;
					root_q <= (root_q >> 1) + sbit;
				end else begin
					root_q <= root_q >> 1;
				end
			end
			OP_CORD_INI: begin
				// final root is below 2^32
				cx_q   <= {4'b0000, root_q[31:0]};
				cy_q   <= {{4{num[15]}}, num, 16'd0};
				cz_q   <= '0;
				zero_q <= (root_q == '0) && (num == '0);
			end
			OP_CORD_STP: begin
				if (!cy_q[35]) begin
					cx_q <= cx_q + shx;
					cy_q <= cy_q - shy;
					cz_q <= cz_q + at;
				end else begin
					cx_q <= cx_q - shx;
					cy_q <= cy_q + shy;
					cz_q <= cz_q - at;
				end
			end
			OP_POST: begin
				dx_q <= adx;
				dy_q <= ady;
				xc_q <= xc;
				yc_q <= yc;
			end
			OP_SCALE: begin
				case (cmd.step[1:0])
					2'd0: res_xr_q <= sc_out;
					2'd1: res_yr_q <= sc_out;
					2'd2: res_dx_q <= sc_out;
					default: res_dy_q <= sc_out;
				endcase
			end
			OP_PUBLISH: begin
				x_rotation <= res_xr_q;
				y_rotation <= res_yr_q;
				delta_x    <= res_dx_q;
				delta_y    <= res_dy_q;
				x_changed  <= xc_q;
				y_changed  <= yc_q;
			end
			default: ;
		endcase
	end

endmodule

// ----- design/accel_tilt_angle_deadband_core.sv -----
// Top level of the accelerometer tilt angle block with deadband.
//
// Input channel s_*: one item is one accelerometer sample (tdata = x, y, z,
// 16-bit signed each) with tuser = mode. Mode 1 is a calibrate item: the last
// pitch and roll become the new offsets, no result is produced and the block
// is ready again in the next cycle.
// Output channel m_*: one result item per sample item, carrying the held x/y
// rotations, their deltas and the change flags, in radians*8192 or deg*128.
// For each of pitch and roll, a sample goes through two squares on one
// multiplier, 32 steps of the bitwise square root and 16 CORDIC vectoring
// steps; then come the deadband update, four scaling steps on one
// multiplier and the output load. One sample is in flight at a time: no
// new sample is taken until the last one has reached the output load.
// The result sits in an output register; the next sample is taken while it
// waits. If the receiver stalls, the following result waits inside the block
// and no new sample is taken until the output register frees up.
// Reset clears angles, offsets and held values to zero, the threshold to 182
// and the unit to radians. Configuration: cfg_we with cfg_index and cfg_wdata.
module accel_tilt_angle_deadband_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // accel_x, accel_y, accel_z
	input  logic        s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // x_rotation, y_rotation, delta_x, delta_y,
	                               // x_changed, y_changed, zero pad
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [14:0] cfg_wdata
);
	import atd_pkg::*;

	logic [THR_BITS-1:0] thr_q;
	logic                unit_q;
	cmd_t                cmd;
	logic signed [14:0]  x_rotation, y_rotation;
	logic [14:0]         delta_x, delta_y;
	logic                x_changed, y_changed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THRESHOLD_RESET;
			unit_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_THRESHOLD && cfg_wdata <= THRESHOLD_MAX) begin
				thr_q <= cfg_wdata;
			end
			if (cfg_index == REG_UNIT) begin
				unit_q <= cfg_wdata[0];
			end
		end
	end

	atd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_mode  (s_tuser),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.cmd      (cmd)
	);

	atd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.accel_x   (s_tdata[15:0]),
		.accel_y   (s_tdata[31:16]),
		.accel_z   (s_tdata[47:32]),
		.threshold (thr_q),
		.unit_deg  (unit_q),
		.x_rotation(x_rotation),
		.y_rotation(y_rotation),
		.delta_x   (delta_x),
		.delta_y   (delta_y),
		.x_changed (x_changed),
		.y_changed (y_changed)
	);

	assign m_tdata = {2'b00, y_changed, x_changed, delta_y, delta_x, y_rotation, x_rotation};

	// a sample item keeps the block busy on the following cycle
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser |=> !s_tready)
		else $error("input taken right after a sample item");

	// a calibrate item leaves the block ready
	a_cal_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> s_tready)
		else $error("block busy after calibrate item");

	// folded angles stay within +-pi/2 in either unit
	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(x_rotation) <= 15'sd12868 && $signed(x_rotation) >= -15'sd12868
			&& $signed(y_rotation) <= 15'sd12868 && $signed(y_rotation) >= -15'sd12868))
		else $error("rotation out of range");

endmodule

// ----- dv/accel_tilt_angle_deadband_core_tb.sv -----
// Testbench for the tilt angle block: directed and random samples checked against a predictor.
`timescale 1ns / 100ps

module accel_tilt_angle_deadband_core_tb;
	import atd_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int DRAIN_CYCLES   = 150;

	// lowest field last, to match the m_tdata packing
	typedef struct packed {
		logic        yc;
		logic        xc;
		logic [14:0] dy;
		logic [14:0] dx;
		logic [14:0] y_rot;
		logic [14:0] x_rot;
	} tilt_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        cfg_we;
	logic        cfg_index;
	logic [14:0] cfg_wdata;

	accel_tilt_angle_deadband_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// predictor state
	longint mdl_thr, mdl_unit;
	longint mdl_pitch, mdl_roll, mdl_pitch_off, mdl_roll_off, mdl_held_x, mdl_held_y;

	tilt_result_t expected_tilt[$];
	int errors, n_samples, n_cals, n_results, n_cfg;
	int tx_idle_pct, rx_idle_pct, hold_len, quiet_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint wrap16(longint v);
		return longint'(shortint'(v[15:0]));
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint z, ddx, ddy;
		z = 0;
		if (x == 0 && y == 0) return 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			ddx = y >>> i;
			ddy = x >>> i;
			if (y >= 0) begin
				x += ddx; y -= ddy; z += longint'(atan_entry(5'(i)));
			end else begin
				x -= ddx; y += ddy; z -= longint'(atan_entry(5'(i)));
			end
		end
		return (z + (64'sd1 << 15)) >>> 16;
	endfunction

	function automatic longint tilt_of(longint num, longint a, longint b);
		longint unsigned sum;
		sum = longint'(a * a + b * b);
		return vector_angle(num <<< 16, longint'(int_sqrt(sum << 32)));
	endfunction

	function automatic longint fold_half(longint v);
		if (v > 16384) return 32768 - v;
		if (v < -16384) return -32768 - v;
		return v;
	endfunction

	function automatic logic [14:0] to_unit(longint u);
		longint unsigned mag, r;
		mag = (u < 0) ? -u : u;
		if (mdl_unit != 0) r = (mag * 45 + 32) >> 6;
		else r = (mag * 51472 + 32768) >> 16;
		return (u < 0) ? 15'(-r) : 15'(r);
	endfunction

	function automatic void predict_item(logic mode, logic [47:0] d);
		longint ax, ay, az, xr, yr, ddx, ddy;
		tilt_result_t r;
		if (mode) begin
			mdl_pitch_off = mdl_pitch;
			mdl_roll_off = mdl_roll;
			return;
		end
		ax = longint'(signed'(d[15:0]));
		ay = longint'(signed'(d[31:16]));
		az = longint'(signed'(d[47:32]));
		mdl_pitch = wrap16(-tilt_of(ax, ay, az));
		mdl_roll = wrap16(tilt_of(ay, ax, az));
		xr = fold_half(wrap16(mdl_roll - mdl_roll_off));
		yr = fold_half(wrap16(mdl_pitch - mdl_pitch_off));
		ddx = xr - mdl_held_x;
		ddy = yr - mdl_held_y;
		if (ddx < 0) ddx = -ddx;
		if (ddy < 0) ddy = -ddy;
		r.xc = ddx >= mdl_thr;
		r.yc = ddy >= mdl_thr;
		if (r.xc) mdl_held_x = xr;
		if (r.yc) mdl_held_y = yr;
		r.x_rot = to_unit(mdl_held_x);
		r.y_rot = to_unit(mdl_held_y);
		r.dx = to_unit(ddx);
		r.dy = to_unit(ddy);
		expected_tilt.push_back(r);
	endfunction

	task automatic send_item(logic mode, logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
		@(negedge clk);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {az, ay, ax};
		do @(posedge clk); while (!s_tready);
		predict_item(mode, {az, ay, ax});
		if (mode) n_cals++;
		else n_samples++;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (expected_tilt.size() == 0);
		// a trailing calibrate may still be in flight
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [14:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_THRESHOLD) begin
			if (val <= THRESHOLD_MAX) mdl_thr = val;
		end else begin
			mdl_unit = val[0];
		end
		n_cfg++;
	endtask

	function automatic logic [15:0] rand_accel();
		case ($urandom_range(4))
			0: return 16'($urandom);
			1: return 16'($urandom_range(4000) - 2000);
			2: case ($urandom_range(4))
				0: return 16'h8000;
				1: return 16'h7FFF;
				2: return 16'h0000;
				3: return 16'hFFFF;
				default: return 16'h0001;
			endcase
			default: return 16'($urandom_range(32768) - 16384);
		endcase
	endfunction

	task automatic test_directed();
		send_item(1'b0, 16'h0000, 16'h0000, 16'h0000);    // zero vector
		send_item(1'b0, 16'h7FFF, 16'h0000, 16'h0000);
		send_item(1'b0, 16'h8000, 16'h0000, 16'h0000);
		send_item(1'b0, 16'h0000, 16'h7FFF, 16'h0000);
		send_item(1'b0, 16'h0000, 16'h8000, 16'h0000);
		send_item(1'b0, 16'h0000, 16'h0000, 16'h7FFF);
		send_item(1'b0, 16'h0000, 16'h0000, 16'h8000);
		send_item(1'b0, 16'h8000, 16'h8000, 16'h8000);
		send_item(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		// calibrate at a steep roll, then swing the other way to reach the wrap and fold
		send_item(1'b0, 16'h0000, 16'h7FFF, 16'h0001);
		send_item(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(1'b0, 16'h0000, 16'h8000, 16'h0001);
		send_item(1'b0, 16'h0000, 16'h8000, 16'hFFFF);
		send_item(1'b1, 16'h0000, 16'h0000, 16'h0000);
		send_item(1'b1, 16'h0000, 16'h0000, 16'h0000);
		send_item(1'b0, 16'h1234, 16'hABCD, 16'h5555);
		send_item(1'b0, 16'h0001, 16'hFFFF, 16'h4000);
		drain();
	endtask

	task automatic test_registers();
		write_reg(REG_THRESHOLD, 15'd0);       // every sample updates
		write_reg(REG_UNIT, 15'd1);
		repeat (4) send_item(1'b0, rand_accel(), rand_accel(), rand_accel());
		drain();
		write_reg(REG_THRESHOLD, 15'd16384);
		write_reg(REG_THRESHOLD, 15'd16385);   // ignored
		write_reg(REG_THRESHOLD, 15'h7FFF);    // ignored
		write_reg(REG_UNIT, 15'h7FFE);         // bit 0 only
		send_item(1'b0, 16'h7FFF, 16'h0000, 16'h0000);
		send_item(1'b0, 16'h8000, 16'h8000, 16'h0000);
		send_item(1'b0, 16'h0000, 16'h7FFF, 16'h0000);
		drain();
		write_reg(REG_THRESHOLD, 15'd182);
		write_reg(REG_UNIT, 15'd0);
	endtask

	task automatic test_random(int count);
		logic [14:0] thr_pick[5];
		thr_pick = '{15'd0, 15'd1, 15'd182, 15'd3000, 15'd16384};
		for (int i = 0; i < count; i++) begin
			if (i % 160 == 159) begin
				drain();
				write_reg(REG_THRESHOLD, ($urandom_range(3) == 0) ? 15'($urandom)
					: thr_pick[$urandom_range(4)]);
				write_reg(REG_UNIT, 15'($urandom));
			end
			send_item($urandom_range(19) == 0, rand_accel(), rand_accel(), rand_accel());
		end
		drain();
	endtask

	task automatic test_backpressure();
		hold_len = 1500;
		repeat (5) send_item(1'b0, rand_accel(), rand_accel(), rand_accel());
		drain();
	endtask

	always @(negedge clk) begin
		if (hold_len > 0) begin
			m_tready <= 1'b0;
			hold_len <= hold_len - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		tilt_result_t got, exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[61:0];
			n_results++;
			if (expected_tilt.size() == 0) begin
				$error("unexpected result item %h", m_tdata);
				errors++;
			end else begin
				exp_r = expected_tilt.pop_front();
				if (got.x_rot !== exp_r.x_rot) begin
					$error("x_rotation exp %0d got %0d", signed'(exp_r.x_rot), signed'(got.x_rot));
					errors++;
				end
				if (got.y_rot !== exp_r.y_rot) begin
					$error("y_rotation exp %0d got %0d", signed'(exp_r.y_rot), signed'(got.y_rot));
					errors++;
				end
				if (got.dx !== exp_r.dx) begin
					$error("delta_x exp %0d got %0d", exp_r.dx, got.dx);
					errors++;
				end
				if (got.dy !== exp_r.dy) begin
					$error("delta_y exp %0d got %0d", exp_r.dy, got.dy);
					errors++;
				end
				if (got.xc !== exp_r.xc) begin
					$error("x_changed exp %0d got %0d", exp_r.xc, got.xc);
					errors++;
				end
				if (got.yc !== exp_r.yc) begin
					$error("y_changed exp %0d got %0d", exp_r.yc, got.yc);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("accel_tilt_angle_deadband_core_tb: FAIL");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_wdata = '0;
		hold_len = 0;
		quiet_cycles = 0;
		errors = 0;
		n_samples = 0; n_cals = 0; n_results = 0; n_cfg = 0;
		mdl_thr = THRESHOLD_RESET;
		mdl_unit = 0;
		mdl_pitch = 0; mdl_roll = 0; mdl_pitch_off = 0; mdl_roll_off = 0;
		mdl_held_x = 0; mdl_held_y = 0;
		tx_idle_pct = 12;
		rx_idle_pct = 59;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_registers();
		test_random(650);
		tx_idle_pct = 59;
		rx_idle_pct = 12;
		test_random(650);
		test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random(620);

		drain();
		$display("covered %0d samples, %0d calibrates, %0d results, %0d register writes",
			n_samples, n_cals, n_results, n_cfg);
		$display("both units, thresholds 0..16384 with rejected writes, long output stall");
		if (errors == 0)
			$display("accel_tilt_angle_deadband_core_tb: PASS");
		else
			$display("accel_tilt_angle_deadband_core_tb: FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
design/atd_pkg.sv
design/atd_ctrl.sv
design/atd_dp.sv
design/accel_tilt_angle_deadband_core.sv
dv/accel_tilt_angle_deadband_core_tb.sv
